@@ hw/rtl/rti_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rti_pkg;

	localparam int CRD_W   = 32;           // vertex / origin coordinate
	localparam int DIR_W   = 18;           // direction component
	localparam int DIF_W   = CRD_W + 1;    // edge and origin-offset vectors
	localparam int P_W     = DIR_W + DIF_W + 1;   // dir x e1
	localparam int Q_W     = 2 * DIF_W + 1;       // T x e0
	localparam int PLO_W   = P_W / 2;      // low (unsigned) half of P
	localparam int PHI_W   = P_W - PLO_W;
	localparam int QLO_W   = (Q_W + 1) / 2;
	localparam int QHI_W   = Q_W - QLO_W;
	localparam int SUM_W   = 104;          // holds every dot product with margin
	localparam int DIV_W   = 120;          // (eq << 16) and det << 31
	localparam int DIST_W  = 31;
	localparam int FRAC_W  = 16;
	localparam int DIV_STAGES = DIST_W + 1;
	localparam int AW      = 5;
	localparam int DATA_W  = 32;
	localparam int NUM_VTX_FIELDS = 9;

	typedef enum logic [2:0] {
		REG_ORG_X,
		REG_ORG_Y,
		REG_ORG_Z,
		REG_DIR_X,
		REG_DIR_Y,
		REG_DIR_Z,
		REG_DET_MIN
	} reg_idx_t;

	// payload into the divider
	typedef struct packed {
		logic             hit;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_in_t;

endpackage
`default_nettype wire

@@ hw/rtl/rti_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, saturating: a saturation check stage, then one quotient bit per stage.
module rti_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  rti_pkg::div_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         out_hit,
	output logic [rti_pkg::DIST_W-1:0]   out_dist
);

	localparam int NS = rti_pkg::DIV_STAGES;

	logic [NS-1:0] v_s;
	logic [NS-1:0] en;
	logic [rti_pkg::DIV_W-1:0]  rem_s [NS];
	logic [rti_pkg::DIV_W-1:0]  den_s [NS];
	logic [rti_pkg::DIST_W-1:0] quo_s [NS];
	logic [NS-1:0] sat_s;
	logic [NS-1:0] hit_s;

	assign en[NS-1] = !v_s[NS-1] || out_ready;
	for (genvar j = 0; j < NS - 1; j++) begin : g_en
		assign en[j] = !v_s[j] || en[j+1];
	end
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) begin
				v_s[0] <= in_valid;
			end
			for (int j = 1; j < NS; j++) begin
				if (en[j]) begin
					v_s[j] <= v_s[j-1];
				end
			end
		end
	end

	// first stage: saturation check against den * 2^31
	// later stages: quotient bit DIST_W-j from den << (DIST_W-j)
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= in_data.num;
			den_s[0] <= in_data.den;
			quo_s[0] <= '0;
			hit_s[0] <= in_data.hit;
			sat_s[0] <= !(in_data.num < (in_data.den << rti_pkg::DIST_W));
		end
		for (int j = 1; j < NS; j++) begin
			if (en[j]) begin
				if (!sat_s[j-1]
					&& (rem_s[j-1] >= (den_s[j-1] << (rti_pkg::DIST_W - j)))) begin
					rem_s[j] <= rem_s[j-1] - (den_s[j-1] << (rti_pkg::DIST_W - j));
					quo_s[j] <= quo_s[j-1]
						| (rti_pkg::DIST_W'(1) << (rti_pkg::DIST_W - j));
				end else begin
					rem_s[j] <= rem_s[j-1];
					quo_s[j] <= quo_s[j-1];
				end
				den_s[j] <= den_s[j-1];
				sat_s[j] <= sat_s[j-1];
				hit_s[j] <= hit_s[j-1];
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_hit   = hit_s[NS-1];
	always_comb begin
		if (!hit_s[NS-1]) begin
			out_dist = '0;
		end else if (sat_s[NS-1]) begin
			out_dist = '1;
		end else begin
			out_dist = quo_s[NS-1];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/ray_triangle_intersect_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Moller-Trumbore ray/triangle test, exact fixed point, fully pipelined.
// Pipeline: 8 geometry stages, then 32 divider stages. Throughput: one triangle per
// cycle while the output is not stalled.
// Each stage holds its item only while the next stage is full and stalled.
// arst_n clears all valid bits and the ray registers (dir_z = 1.0, rest 0).
module ray_triangle_intersect_core (
	input  logic                       clk,
	input  logic                       arst_n,
	// triangle in: v0_x,v0_y,v0_z,v1_x,v1_y,v1_z,v2_x,v2_y,v2_z (32 b each)
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [287:0]               s_tdata,
	// result: m_tdata = distance[30:0], 0 in bit 31; m_tuser = hit
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,
	output logic [0:0]                 m_tuser,
	// register port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rti_pkg::AW-1:0]     paddr,
	input  logic [rti_pkg::DATA_W-1:0] pwdata,
	output logic [rti_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int CW = rti_pkg::CRD_W;
	localparam int DW = rti_pkg::DIR_W;
	localparam int FW = rti_pkg::DIF_W;
	localparam int SW = rti_pkg::SUM_W;
	localparam int GS = 8;

	// ---------------- configuration registers ----------------
	logic signed [CW-1:0] org_q [3];
	logic signed [DW-1:0] dir_q [3];
	logic        [CW-1:0] det_min_q;
	rti_pkg::reg_idx_t    reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = rti_pkg::reg_idx_t'(paddr[rti_pkg::AW-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
			end
			dir_q[0]  <= '0;
			dir_q[1]  <= '0;
			dir_q[2]  <= DW'(1 << rti_pkg::FRAC_W);
			det_min_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				rti_pkg::REG_ORG_X:   org_q[0]  <= pwdata;
				rti_pkg::REG_ORG_Y:   org_q[1]  <= pwdata;
				rti_pkg::REG_ORG_Z:   org_q[2]  <= pwdata;
				rti_pkg::REG_DIR_X:   dir_q[0]  <= pwdata[DW-1:0];
				rti_pkg::REG_DIR_Y:   dir_q[1]  <= pwdata[DW-1:0];
				rti_pkg::REG_DIR_Z:   dir_q[2]  <= pwdata[DW-1:0];
				rti_pkg::REG_DET_MIN: det_min_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rti_pkg::REG_ORG_X:   prdata = org_q[0];
			rti_pkg::REG_ORG_Y:   prdata = org_q[1];
			rti_pkg::REG_ORG_Z:   prdata = org_q[2];
			rti_pkg::REG_DIR_X:   prdata = {{(rti_pkg::DATA_W-DW){1'b0}}, dir_q[0]};
			rti_pkg::REG_DIR_Y:   prdata = {{(rti_pkg::DATA_W-DW){1'b0}}, dir_q[1]};
			rti_pkg::REG_DIR_Z:   prdata = {{(rti_pkg::DATA_W-DW){1'b0}}, dir_q[2]};
			rti_pkg::REG_DET_MIN: prdata = det_min_q;
			default:              prdata = '0;
		endcase
	end

	// ---------------- stall chain ----------------
	// A stage loads when it is empty or its successor moves on.
	logic [GS:1] gv_s;
	logic [GS:1] gen;
	logic        div_ready;

	assign gen[GS] = !gv_s[GS] || div_ready;
	for (genvar i = 1; i < GS; i++) begin : g_en
		assign gen[i] = !gv_s[i] || gen[i+1];
	end
	assign s_tready = gen[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gv_s <= '0;
		end else begin
			if (gen[1]) begin
				gv_s[1] <= s_tvalid;
			end
			for (int i = 2; i <= GS; i++) begin
				if (gen[i]) begin
					gv_s[i] <= gv_s[i-1];
				end
			end
		end
	end

	// ---------------- stage 1: edges and origin offset ----------------
	logic signed [CW-1:0] vtx [rti_pkg::NUM_VTX_FIELDS];
	logic signed [FW-1:0] e0_s1 [3], e1_s1 [3], tv_s1 [3];

	always_comb begin
		for (int k = 0; k < rti_pkg::NUM_VTX_FIELDS; k++) begin
			vtx[k] = s_tdata[CW*k +: CW];
		end
	end

	always_ff @(posedge clk) begin
		if (gen[1]) begin
			for (int i = 0; i < 3; i++) begin
				e0_s1[i] <= FW'(vtx[3+i]) - FW'(vtx[i]);
				e1_s1[i] <= FW'(vtx[6+i]) - FW'(vtx[i]);
				tv_s1[i] <= FW'(org_q[i]) - FW'(vtx[i]);
			end
		end
	end

	// ---------------- stage 2: P = dir x e1, Q = T x e0 ----------------
	logic signed [DW+FW-1:0]  pm [6];
	logic signed [2*FW-1:0]   qm [6];
	logic signed [rti_pkg::P_W-1:0] p_s2 [3];
	logic signed [rti_pkg::Q_W-1:0] q_s2 [3];
	logic signed [FW-1:0] e0_s2 [3], e1_s2 [3], tv_s2 [3];

	always_comb begin
		pm[0] = dir_q[1] * e1_s1[2];  pm[1] = dir_q[2] * e1_s1[1];
		pm[2] = dir_q[2] * e1_s1[0];  pm[3] = dir_q[0] * e1_s1[2];
		pm[4] = dir_q[0] * e1_s1[1];  pm[5] = dir_q[1] * e1_s1[0];
		qm[0] = tv_s1[1] * e0_s1[2];  qm[1] = tv_s1[2] * e0_s1[1];
		qm[2] = tv_s1[2] * e0_s1[0];  qm[3] = tv_s1[0] * e0_s1[2];
		qm[4] = tv_s1[0] * e0_s1[1];  qm[5] = tv_s1[1] * e0_s1[0];
	end

	always_ff @(posedge clk) begin
		if (gen[2]) begin
			for (int i = 0; i < 3; i++) begin
				p_s2[i]  <= rti_pkg::P_W'(pm[2*i]) - rti_pkg::P_W'(pm[2*i+1]);
				q_s2[i]  <= rti_pkg::Q_W'(qm[2*i]) - rti_pkg::Q_W'(qm[2*i+1]);
				e0_s2[i] <= e0_s1[i];
				e1_s2[i] <= e1_s1[i];
				tv_s2[i] <= tv_s1[i];
			end
		end
	end

	// ---------------- stage 3: split products ----------------
	// P and Q are cut into a signed high half and an unsigned low half.
	localparam int PLW = rti_pkg::PLO_W;
	localparam int PHW = rti_pkg::PHI_W;
	localparam int QLW = rti_pkg::QLO_W;
	localparam int QHW = rti_pkg::QHI_W;

	logic signed [PLW:0]   plo [3];
	logic signed [PHW-1:0] phi [3];
	logic signed [QLW:0]   qlo [3];
	logic signed [QHW-1:0] qhi [3];
	logic signed [FW+PLW:0]   det_lo_s3 [3], tp_lo_s3 [3];
	logic signed [FW+PHW-1:0] det_hi_s3 [3], tp_hi_s3 [3];
	logic signed [DW+QLW:0]   dq_lo_s3 [3];
	logic signed [DW+QHW-1:0] dq_hi_s3 [3];
	logic signed [FW+QLW:0]   eq_lo_s3 [3];
	logic signed [FW+QHW-1:0] eq_hi_s3 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			plo[i] = $signed({1'b0, p_s2[i][PLW-1:0]});
			phi[i] = $signed(p_s2[i][rti_pkg::P_W-1:PLW]);
			qlo[i] = $signed({1'b0, q_s2[i][QLW-1:0]});
			qhi[i] = $signed(q_s2[i][rti_pkg::Q_W-1:QLW]);
		end
	end

	always_ff @(posedge clk) begin
		if (gen[3]) begin
			for (int i = 0; i < 3; i++) begin
				det_lo_s3[i] <= e0_s2[i] * plo[i];
				det_hi_s3[i] <= e0_s2[i] * phi[i];
				tp_lo_s3[i]  <= tv_s2[i] * plo[i];
				tp_hi_s3[i]  <= tv_s2[i] * phi[i];
				dq_lo_s3[i]  <= dir_q[i] * qlo[i];
				dq_hi_s3[i]  <= dir_q[i] * qhi[i];
				eq_lo_s3[i]  <= e1_s2[i] * qlo[i];
				eq_hi_s3[i]  <= e1_s2[i] * qhi[i];
			end
		end
	end

	// ---------------- stage 4: recombine halves ----------------
	logic signed [SW-1:0] det_t_s4 [3], tp_t_s4 [3], dq_t_s4 [3], eq_t_s4 [3];

	always_ff @(posedge clk) begin
		if (gen[4]) begin
			for (int i = 0; i < 3; i++) begin
				det_t_s4[i] <= (SW'(det_hi_s3[i]) <<< PLW) + SW'(det_lo_s3[i]);
				tp_t_s4[i]  <= (SW'(tp_hi_s3[i]) <<< PLW) + SW'(tp_lo_s3[i]);
				dq_t_s4[i]  <= (SW'(dq_hi_s3[i]) <<< QLW) + SW'(dq_lo_s3[i]);
				eq_t_s4[i]  <= (SW'(eq_hi_s3[i]) <<< QLW) + SW'(eq_lo_s3[i]);
			end
		end
	end

	// ---------------- stage 5: dot products ----------------
	logic signed [SW-1:0] det_s5, tp_s5, dq_s5, eq_s5;

	always_ff @(posedge clk) begin
		if (gen[5]) begin
			det_s5 <= det_t_s4[0] + det_t_s4[1] + det_t_s4[2];
			tp_s5  <= tp_t_s4[0] + tp_t_s4[1] + tp_t_s4[2];
			dq_s5  <= dq_t_s4[0] + dq_t_s4[1] + dq_t_s4[2];
			eq_s5  <= eq_t_s4[0] + eq_t_s4[1] + eq_t_s4[2];
		end
	end

	// ---------------- stage 6: sign normalization ----------------
	// Flip all numerators with det so every test compares against |det|.
	logic                 flip;
	logic signed [SW-1:0] adet_s6, tp_s6, dq_s6, eq_s6;

	assign flip = det_s5[SW-1];

	always_ff @(posedge clk) begin
		if (gen[6]) begin
			adet_s6 <= flip ? -det_s5 : det_s5;
			tp_s6   <= flip ? -tp_s5  : tp_s5;
			dq_s6   <= flip ? -dq_s5  : dq_s5;
			eq_s6   <= flip ? -eq_s5  : eq_s5;
		end
	end

	// ---------------- stage 7: range tests ----------------
	// not parallel, 0 <= u <= det, v >= 0, t > 0; u+v formed here
	logic signed [SW-1:0] dmin_ext;
	logic                 ok_s7;
	logic signed [SW-1:0] adet_s7, tpdq_s7, eq_s7;

	assign dmin_ext = $signed(SW'(det_min_q));

	always_ff @(posedge clk) begin
		if (gen[7]) begin
			ok_s7   <= (adet_s6 > dmin_ext) && !tp_s6[SW-1] && !(adet_s6 < tp_s6)
				&& !dq_s6[SW-1] && (eq_s6 > 0);
			tpdq_s7 <= tp_s6 + dq_s6;
			adet_s7 <= adet_s6;
			eq_s7   <= eq_s6;
		end
	end

	// ---------------- stage 8: u+v <= det, divider operands ----------------
	rti_pkg::div_in_t div_in_s8;

	always_ff @(posedge clk) begin
		if (gen[8]) begin
			div_in_s8.hit <= ok_s7 && !(adet_s7 < tpdq_s7);
			div_in_s8.num <= rti_pkg::DIV_W'(eq_s7) << rti_pkg::FRAC_W;
			div_in_s8.den <= rti_pkg::DIV_W'(adet_s7);
		end
	end

	// ---------------- distance = floor(eq * 2^16 / |det|) ----------------
	logic                       res_hit;
	logic [rti_pkg::DIST_W-1:0] res_dist;

	rti_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (gv_s[GS]),
		.in_ready  (div_ready),
		.in_data   (div_in_s8),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_hit   (res_hit),
		.out_dist  (res_dist)
	);

	assign m_tdata = {1'b0, res_dist};
	assign m_tuser = res_hit;

endmodule
`default_nettype wire

@@ hw/rtl/rti_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rti_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        pready
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a miss carries zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
		else $error("miss with nonzero distance");

	// distance is 31 bits, pad bit stays clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[31])
		else $error("distance pad bit set");

	// pipeline is empty right after reset
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid && pready)
		else $error("output valid out of reset");

endmodule

bind ray_triangle_intersect_core rti_checker u_rti_checker (.*);
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

	localparam int LATENCY   = 40;
	localparam int N_RANDOM  = 850;
	localparam int CYC_LIMIT = 400000;

	typedef struct packed {
		logic signed [31:0] v2_z, v2_y, v2_x, v1_z, v1_y, v1_x, v0_z, v0_y, v0_x;
	} tri_t;

	typedef struct packed {
		logic        hit;
		logic [30:0] distance;
	} isect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [287:0] s_tdata = '0;   // v0_x,v0_y,v0_z,v1_x,v1_y,v1_z,v2_x,v2_y,v2_z from bit 0
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;        // distance[30:0], zero pad bit 31
	logic [0:0]   m_tuser;        // hit
	logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [rti_pkg::AW-1:0] paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	ray_triangle_intersect_core i_dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// ray as the predictor sees it
	logic signed [31:0] ray_org [3];
	logic signed [17:0] ray_dir [3];
	logic [31:0]        ray_det_min;

	tri_t   tri_pending [$];
	isect_t isect_expected [$];
	int     n_err = 0;
	int     cyc = 0;
	bit     drain_mode = 1'b0;   // no stalls late in the run
	bit     feed_on = 1'b0;

	// 128-bit exact Moller-Trumbore
	function automatic isect_t predict_isect(tri_t tr);
		logic signed [127:0] p0[3], e0[3], e1[3], tv[3], dv[3], pv[3], qv[3];
		logic signed [127:0] det, tp, dq, eq, num, den;
		logic [127:0] q;
		isect_t r;
		r = '0;
		p0[0] = tr.v0_x; p0[1] = tr.v0_y; p0[2] = tr.v0_z;
		e0[0] = 128'(signed'(tr.v1_x)) - p0[0];
		e0[1] = 128'(signed'(tr.v1_y)) - p0[1];
		e0[2] = 128'(signed'(tr.v1_z)) - p0[2];
		e1[0] = 128'(signed'(tr.v2_x)) - p0[0];
		e1[1] = 128'(signed'(tr.v2_y)) - p0[1];
		e1[2] = 128'(signed'(tr.v2_z)) - p0[2];
		for (int i = 0; i < 3; i++) begin
			tv[i] = 128'(signed'(ray_org[i])) - p0[i];
			dv[i] = ray_dir[i];
		end
		pv[0] = dv[1]*e1[2] - dv[2]*e1[1];
		pv[1] = dv[2]*e1[0] - dv[0]*e1[2];
		pv[2] = dv[0]*e1[1] - dv[1]*e1[0];
		det = e0[0]*pv[0] + e0[1]*pv[1] + e0[2]*pv[2];
		tp = tv[0]*pv[0] + tv[1]*pv[1] + tv[2]*pv[2];
		qv[0] = tv[1]*e0[2] - tv[2]*e0[1];
		qv[1] = tv[2]*e0[0] - tv[0]*e0[2];
		qv[2] = tv[0]*e0[1] - tv[1]*e0[0];
		dq = dv[0]*qv[0] + dv[1]*qv[1] + dv[2]*qv[2];
		eq = e1[0]*qv[0] + e1[1]*qv[1] + e1[2]*qv[2];
		if (det < 0) begin
			det = -det; tp = -tp; dq = -dq; eq = -eq;
		end
		if (det <= $signed({96'd0, ray_det_min})) return r;
		if (tp < 0 || tp > det) return r;
		if (dq < 0 || tp + dq > det) return r;
		if (eq <= 0) return r;
		r.hit = 1'b1;
		num = eq <<< 16;
		den = det;
		if (num >= (den <<< 31)) r.distance = 31'h7FFF_FFFF;
		else begin
			q = num / den;
			r.distance = q[30:0];
		end
		return r;
	endfunction

	// sender: stalls in bursts, predicts at acceptance
	int s_gap = 0;
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			isect_expected.push_back(predict_isect(tri_t'(s_tdata)));
			void'(tri_pending.pop_front());
		end
		if (s_tvalid && !s_tready) begin
			// hold
		end else if (s_gap > 0) begin
			s_gap <= s_gap - 1;
			s_tvalid <= 1'b0;
		end else if (feed_on && tri_pending.size() > 0) begin
			if (!drain_mode && $urandom_range(0, 9) == 0) begin
				s_gap <= $urandom_range(1, 8) - 1;
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= tri_pending[0];
			end
		end else
			s_tvalid <= 1'b0;
	end

	// receiver: random stall bursts, result check per transaction
	int m_gap = 0;
	always @(posedge clk) begin
		isect_t got, want;
		cyc <= cyc + 1;
		if (m_tvalid && m_tready) begin
			got.hit = m_tuser[0];
			got.distance = m_tdata[30:0];
			if (isect_expected.size() == 0) begin
				$display("%0t: unexpected result hit=%0d dist=%0h", $time, got.hit,
					got.distance);
				n_err <= n_err + 1;
			end else begin
				want = isect_expected.pop_front();
				if (got !== want || m_tdata[31] !== 1'b0) begin
					$display("%0t: mismatch expected hit=%0d dist=%0h actual hit=%0d dist=%0h",
						$time, want.hit, want.distance, got.hit, got.distance);
					n_err <= n_err + 1;
				end
			end
		end
		if (drain_mode) m_tready <= 1'b1;
		else if (m_gap > 0) begin
			m_gap <= m_gap - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			m_gap <= $urandom_range(1, 8) - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if (cyc > CYC_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// APB write, mirrored into the predictor's copy
	task automatic reg_write(rti_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= rti_pkg::AW'(4 * int'(idx)); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx) inside
			rti_pkg::REG_ORG_X, rti_pkg::REG_ORG_Y, rti_pkg::REG_ORG_Z:
				ray_org[int'(idx)] = val;
			rti_pkg::REG_DIR_X, rti_pkg::REG_DIR_Y, rti_pkg::REG_DIR_Z:
				ray_dir[int'(idx) - 3] = val[17:0];
			default: ray_det_min = val;
		endcase
	endtask

	task automatic set_ray(logic [31:0] ox, oy, oz, logic [17:0] dx, dy, dz, logic [31:0] dm);
		reg_write(rti_pkg::REG_ORG_X, ox); reg_write(rti_pkg::REG_ORG_Y, oy);
		reg_write(rti_pkg::REG_ORG_Z, oz);
		reg_write(rti_pkg::REG_DIR_X, 32'(signed'(dx)));
		reg_write(rti_pkg::REG_DIR_Y, 32'(signed'(dy)));
		reg_write(rti_pkg::REG_DIR_Z, 32'(signed'(dz)));
		reg_write(rti_pkg::REG_DET_MIN, dm);
	endtask

	// send queued triangles then wait until all results are back
	task automatic run_and_drain();
		feed_on = 1'b1;
		while (tri_pending.size() > 0 || s_tvalid) @(posedge clk);
		feed_on = 1'b0;
		while (isect_expected.size() > 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic tri_t make_tri(int c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z);
		tri_t t;
		t.v0_x = c0x; t.v0_y = c0y; t.v0_z = c0z;
		t.v1_x = c1x; t.v1_y = c1y; t.v1_z = c1z;
		t.v2_x = c2x; t.v2_y = c2y; t.v2_z = c2z;
		return t;
	endfunction

	// triangle around the ray, hit likely; scale and offset random
	function automatic tri_t rand_hit_tri();
		int s, d, cx, cy;
		s = $urandom_range(1, 1 << $urandom_range(1, 22));
		d = $urandom_range(0, 1 << $urandom_range(0, 24)) - (1 << 12);
		cx = ray_org[0]; cy = ray_org[1];
		return make_tri(cx - s, cy - s, ray_org[2] + d + int'($urandom_range(0, 255)),
			cx + s + int'($urandom_range(0, s)), cy - s, ray_org[2] + d,
			cx, cy + s + int'($urandom_range(0, s)), ray_org[2] + d - int'($urandom_range(0, 255)));
	endfunction

	function automatic tri_t rand_tri();
		tri_t t;
		t = rand_hit_tri();
		case ($urandom_range(0, 9))
			0, 1: t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom};
			2: begin
				t.v1_x = t.v0_x; t.v1_y = t.v0_y; t.v1_z = t.v0_z;  // degenerate
			end
			3: t.v0_z = -t.v0_z;
			default: ;
		endcase
		return t;
	endfunction

	initial begin
		tri_t t;
		logic [17:0] dir_pool [6];
		ray_org = '{0, 0, 0}; ray_dir = '{0, 0, 18'sd65536}; ray_det_min = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset ray: straight down +z from the origin
		tri_pending.push_back(make_tri(-65536, -65536, 131072, 65536, -65536, 131072,
			0, 65536, 131072));                                      // hit at t=2
		tri_pending.push_back(make_tri(-65536, -65536, -131072, 65536, -65536, -131072,
			0, 65536, -131072));                                     // behind origin
		tri_pending.push_back(make_tri(0, 0, 0, 65536, 0, 65536, 0, 65536, 65536)); // vertex at the origin, t = 0
		tri_pending.push_back(make_tri(0, 0, 1, 65536, 0, 1, 0, 65536, 1)); // vertex hit, tiny t
		tri_pending.push_back(make_tri(-1, -1, 32'h7FFF_FFFF, 65536, -1, 32'h7FFF_FFFF,
			-1, 65536, 32'h7FFF_FFFF));                            // far
		tri_pending.push_back(make_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF));
		tri_pending.push_back({9{32'hFFFF_FFFF}});
		tri_pending.push_back('0);
		tri_pending.push_back(make_tri(65536, 65536, 65536, 131072, 65536, 65536,
			65536, 131072, 65536));                                   // off to the side
		run_and_drain();

		// huge distance: tiny direction, slow extreme origin
		set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 18'sd1, 18'sd1, 18'sd1, 0);
		tri_pending.push_back(make_tri(32'h7FFF_0000, 32'h7FF0_0000, 32'h7FFF_FFFF,
			32'h7FF0_0000, 32'h7FFF_FFFF, 32'h7FFF_0000, 32'h7FFF_FFFF, 32'h7FFF_0000,
			32'h7FF0_0000));
		tri_pending.push_back(make_tri(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0));
		run_and_drain();
		// extreme direction and det_min
		set_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 18'h20000, 18'h1FFFF, 18'h20000,
			32'hFFFF_FFFF);
		tri_pending.push_back(make_tri(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0));
		tri_pending.push_back(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
		tri_pending.push_back({9{32'h5555_5555}});
		tri_pending.push_back({9{32'hAAAA_AAAA}});
		run_and_drain();

		// random phases over several ray settings
		dir_pool = '{18'sd65536, -18'sd65536, 18'sd46341, -18'sd46341, 18'sd0, 18'sd37837};
		for (int ph = 0; ph < 10; ph++) begin
			set_ray(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20) - (1 << 19),
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20) - (1 << 19),
				$urandom_range(0, 1 << 20) - (1 << 19),
				(ph % 3 == 2) ? 18'($urandom) : dir_pool[$urandom_range(0, 5)],
				(ph % 3 == 2) ? 18'($urandom) : dir_pool[$urandom_range(0, 5)],
				(ph % 4 == 3) ? 18'($urandom) : dir_pool[$urandom_range(0, 2)],
				(ph % 2) ? $urandom >> $urandom_range(0, 31) : 32'd0);
			drain_mode = (ph == 9);
			for (int k = 0; k < N_RANDOM / 10; k++) begin
				t = rand_tri();
				tri_pending.push_back(t);
			end
			run_and_drain();
		end

		if (n_err == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
